// File: rtl/p2h_pkg.sv
// Shared types and constants for the pixel to hex cell locator.
`timescale 1ns / 1ps

package p2h_pkg;

    localparam int COORD_W = 16;
    localparam int COEF_W  = 24;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_Q_X = 3'd0,
        CFG_COEF_Q_Y = 3'd1,
        CFG_COEF_R_X = 3'd2,
        CFG_COEF_R_Y = 3'd3,
        CFG_ORIGIN_X = 3'd4,
        CFG_ORIGIN_Y = 3'd5
    } t_cfg_idx;

    localparam logic signed [COEF_W-1:0] RST_COEF_Q_X = 24'sd605382;
    localparam logic signed [COEF_W-1:0] RST_COEF_Q_Y = -24'sd349525;
    localparam logic signed [COEF_W-1:0] RST_COEF_R_X = 24'sd0;
    localparam logic signed [COEF_W-1:0] RST_COEF_R_Y = 24'sd699051;

    typedef struct packed {
        logic signed [COORD_W-1:0] pixel_x;
        logic signed [COORD_W-1:0] pixel_y;
    } t_pix_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] cell_q;
        logic signed [COORD_W-1:0] cell_r;
        logic signed [COORD_W-1:0] cell_s;
        logic                      overflow;
    } t_cell_out;

endpackage

// File: rtl/p2h_round.sv
// Round half away from zero of one fixed-point cube coordinate, with its rounding error.
`timescale 1ns / 1ps

module p2h_round #(
    parameter int ACC_W = 44,
    parameter int FRAC  = 20
) (
    input  logic signed [ACC_W-1:0]    i_value,
    output logic signed [ACC_W-FRAC:0] o_int,
    output logic [FRAC:0]              o_err
);

    logic              w_neg;
    logic [ACC_W-1:0]  w_mag;
    logic [ACC_W:0]    w_sum;
    logic [ACC_W-FRAC-1:0] w_k;
    logic [FRAC-1:0]   w_low;

    always_comb begin
        w_neg = i_value[ACC_W-1];
        w_mag = w_neg ? (-i_value) : i_value;
        w_sum = {1'b0, w_mag} + {{(ACC_W-FRAC+1){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
        w_k   = w_sum[ACC_W-1:FRAC];
        o_int = w_neg ? -$signed({1'b0, w_k}) : $signed({1'b0, w_k});
        w_low = w_mag[FRAC-1:0];
        if (w_low[FRAC-1]) begin
            o_err = {1'b1, {FRAC{1'b0}}} - {1'b0, w_low};
        end else begin
            o_err = {1'b0, w_low};
        end
    end

endmodule

// File: rtl/pixel_to_hex_cell_round.sv
// Top level of the pixel to hex cell locator: five-stage pipeline from pixel to cube cell.
`timescale 1ns / 1ps

// The block takes one signed pixel beat per cycle while o_in_ready is high and returns
// one cube cell beat for each, in order. The stages are origin subtraction, the four
// coefficient multiplies, the matrix sums, rounding of q, r and s, and the rebuild of the
// worst-rounded component with saturation. Each stage holds its beat only while the stage
// after it is full and stalled, so bubbles close up and the input stays ready while the
// output waits as long as some stage is still empty. Configuration writes are meant for
// idle periods and take effect on the next accepted beat.
module pixel_to_hex_cell_round #(
    parameter int COEF_FRAC_BITS = 20
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  p2h_pkg::t_pix_in                    i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output p2h_pkg::t_cell_out                  o_out_data,
    input  logic                                i_cfg_we,
    input  logic [p2h_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [p2h_pkg::COEF_W-1:0]          i_cfg_data
);

    import p2h_pkg::*;

    localparam int STAGES = 5;
    localparam int DW     = COORD_W + 1;
    localparam int PROD_W = COEF_W + DW;
    localparam int ACC_W  = COEF_W + COORD_W + 4;
    localparam int IW     = ACC_W - COEF_FRAC_BITS + 1;
    localparam int RW     = IW + 1;

    logic signed [COEF_W-1:0]  r_cqx, r_cqy, r_crx, r_cry;
    logic signed [COORD_W-1:0] r_orgx, r_orgy;

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] w_load;

    logic signed [DW-1:0]     r_dx, r_dy;
    logic signed [PROD_W-1:0] r_pqx, r_pqy, r_prx, r_pry;
    logic signed [ACC_W-1:0]  r_qf, r_rf, r_sf;
    logic signed [IW-1:0]     r_qi, r_ri, r_si;
    logic [COEF_FRAC_BITS:0]  r_qd, r_rd, r_sd;
    t_cell_out                r_out;

    logic signed [ACC_W-1:0]  n_qf, n_rf, n_sf;
    logic signed [IW-1:0]     w_qi, w_ri, w_si;
    logic [COEF_FRAC_BITS:0]  w_qd, w_rd, w_sd;
    logic signed [RW-1:0]     w_q, w_r, w_s;
    t_cell_out                n_out;

    function automatic logic f_ovf(input logic signed [RW-1:0] v);
        logic [RW-COORD_W:0] top;
        top = v[RW-1:COORD_W-1];
        return !((&top) || !(|top));
    endfunction

    function automatic logic signed [COORD_W-1:0] f_clamp(input logic signed [RW-1:0] v);
        logic signed [COORD_W-1:0] res;
        if (f_ovf(v)) begin
            res = v[RW-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end else begin
            res = v[COORD_W-1:0];
        end
        return res;
    endfunction

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cqx  <= RST_COEF_Q_X;
            r_cqy  <= RST_COEF_Q_Y;
            r_crx  <= RST_COEF_R_X;
            r_cry  <= RST_COEF_R_Y;
            r_orgx <= '0;
            r_orgy <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_COEF_Q_X: r_cqx  <= i_cfg_data;
                CFG_COEF_Q_Y: r_cqy  <= i_cfg_data;
                CFG_COEF_R_X: r_crx  <= i_cfg_data;
                CFG_COEF_R_Y: r_cry  <= i_cfg_data;
                CFG_ORIGIN_X: r_orgx <= i_cfg_data[COORD_W-1:0];
                CFG_ORIGIN_Y: r_orgy <= i_cfg_data[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    // A stage loads when it is empty or its beat moves on in the same cycle.
    always_comb begin
        w_load[STAGES-1] = !r_vld[STAGES-1] || i_out_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_load[k] = !r_vld[k] || w_load[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_load[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (w_load[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_comb begin
        n_qf = ACC_W'(r_pqx) + ACC_W'(r_pqy);
        n_rf = ACC_W'(r_prx) + ACC_W'(r_pry);
        n_sf = -(n_qf + n_rf);
    end

    p2h_round #(.ACC_W(ACC_W), .FRAC(COEF_FRAC_BITS)) u_round_q (
        .i_value(r_qf), .o_int(w_qi), .o_err(w_qd)
    );
    p2h_round #(.ACC_W(ACC_W), .FRAC(COEF_FRAC_BITS)) u_round_r (
        .i_value(r_rf), .o_int(w_ri), .o_err(w_rd)
    );
    p2h_round #(.ACC_W(ACC_W), .FRAC(COEF_FRAC_BITS)) u_round_s (
        .i_value(r_sf), .o_int(w_si), .o_err(w_sd)
    );

    // q is rebuilt if its error is strictly largest, else r if its error exceeds s's, else s.
    always_comb begin
        w_q = RW'(r_qi);
        w_r = RW'(r_ri);
        w_s = RW'(r_si);
        if (r_qd > r_rd && r_qd > r_sd) begin
            w_q = -RW'(r_ri) - RW'(r_si);
        end else if (r_rd > r_sd) begin
            w_r = -RW'(r_qi) - RW'(r_si);
        end else begin
            w_s = -RW'(r_qi) - RW'(r_ri);
        end
        n_out.cell_q   = f_clamp(w_q);
        n_out.cell_r   = f_clamp(w_r);
        n_out.cell_s   = f_clamp(w_s);
        n_out.overflow = f_ovf(w_q) || f_ovf(w_r) || f_ovf(w_s);
    end

    always_ff @(posedge i_clk) begin
        if (w_load[0]) begin
            r_dx <= DW'(i_in_data.pixel_x) - DW'(r_orgx);
            r_dy <= DW'(i_in_data.pixel_y) - DW'(r_orgy);
        end
        if (w_load[1]) begin
            r_pqx <= r_dx * r_cqx;
            r_pqy <= r_dy * r_cqy;
            r_prx <= r_dx * r_crx;
            r_pry <= r_dy * r_cry;
        end
        if (w_load[2]) begin
            r_qf <= n_qf;
            r_rf <= n_rf;
            r_sf <= n_sf;
        end
        if (w_load[3]) begin
            r_qi <= w_qi;
            r_ri <= w_ri;
            r_si <= w_si;
            r_qd <= w_qd;
            r_rd <= w_rd;
            r_sd <= w_sd;
        end
        if (w_load[4]) begin
            r_out <= n_out;
        end
    end

    assign o_in_ready  = w_load[0];
    assign o_out_valid = r_vld[STAGES-1];
    assign o_out_data  = r_out;

endmodule

// File: rtl/p2h_chk.sv
// Port-level assertions for the pixel to hex cell locator, bound to the top level.
`timescale 1ns / 1ps

module p2h_chk (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_out_valid,
    input  logic                                i_out_ready,
    input  p2h_pkg::t_cell_out                  o_out_data
);

    import p2h_pkg::*;

    localparam logic signed [COORD_W-1:0] CMAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] CMIN = {1'b1, {(COORD_W-1){1'b0}}};

    logic [COORD_W-1:0] w_sum;
    assign w_sum = o_out_data.cell_q + o_out_data.cell_r + o_out_data.cell_s;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Output beat shown right after reset.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("Stalled output beat changed or dropped.");

    a_plane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.overflow |-> w_sum == '0)
        else $error("Cell off the plane q + r + s = 0 without overflow.");

    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.overflow |->
            (o_out_data.cell_q == CMAX || o_out_data.cell_q == CMIN ||
             o_out_data.cell_r == CMAX || o_out_data.cell_r == CMIN ||
             o_out_data.cell_s == CMAX || o_out_data.cell_s == CMIN))
        else $error("Overflow flagged with no saturated coordinate.");

endmodule

bind pixel_to_hex_cell_round p2h_chk u_p2h_chk (.*);

// File: dv/pixel_to_hex_cell_round_test.sv
// Self-checking testbench for the pixel to hex cell locator with a queue-fed driver and monitor.
`timescale 1ns / 1ps

module pixel_to_hex_cell_round_test;

    import p2h_pkg::*;

    localparam int     FRAC_BITS    = 20;
    localparam int     DRAIN_CYCLES = 12;
    localparam longint ONE          = 64'sd1 <<< FRAC_BITS;
    localparam longint HALF         = ONE >>> 1;
    localparam longint COORD_MAX    = (64'sd1 <<< (COORD_W - 1)) - 1;
    localparam longint COORD_MIN    = -COORD_MAX - 1;
    localparam logic [COEF_W-1:0] COEF_MAX  = 24'h7FFFFF;
    localparam logic [COEF_W-1:0] COEF_MIN  = 24'h800000;
    localparam logic [COEF_W-1:0] COEF_HALF = 24'h080000;
    localparam logic [COEF_W-1:0] ORG_MAX   = 24'h007FFF;
    localparam logic [COEF_W-1:0] ORG_MIN   = 24'h008000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_pix_in              i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_cell_out            o_out_data;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [COEF_W-1:0]    i_cfg_data  = '0;

    logic signed [COEF_W-1:0]  cfg_qx = RST_COEF_Q_X;
    logic signed [COEF_W-1:0]  cfg_qy = RST_COEF_Q_Y;
    logic signed [COEF_W-1:0]  cfg_rx = RST_COEF_R_X;
    logic signed [COEF_W-1:0]  cfg_ry = RST_COEF_R_Y;
    logic signed [COORD_W-1:0] cfg_ox = '0;
    logic signed [COORD_W-1:0] cfg_oy = '0;

    t_pix_in   pix_queue[$];
    t_cell_out cell_expect[$];
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    int        fail_count     = 0;

    pixel_to_hex_cell_round #(
        .COEF_FRAC_BITS(FRAC_BITS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic longint round_half_away(longint v);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + HALF) >>> FRAC_BITS;
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic longint round_error(longint k, longint v);
        longint e;
        e = k * ONE - v;
        return (e < 0) ? -e : e;
    endfunction

    function automatic longint saturate(longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    function automatic t_cell_out predict_cell(t_pix_in pix);
        longint    dx, dy, qf, rf, sf, q, r, s, qe, re, se, qc, rc, sc;
        t_cell_out pred;
        dx = longint'($signed(pix.pixel_x)) - longint'(cfg_ox);
        dy = longint'($signed(pix.pixel_y)) - longint'(cfg_oy);
        qf = longint'(cfg_qx) * dx + longint'(cfg_qy) * dy;
        rf = longint'(cfg_rx) * dx + longint'(cfg_ry) * dy;
        sf = -qf - rf;
        q  = round_half_away(qf);
        r  = round_half_away(rf);
        s  = round_half_away(sf);
        qe = round_error(q, qf);
        re = round_error(r, rf);
        se = round_error(s, sf);
        if (qe > re && qe > se) begin
            q = -r - s;
        end else if (re > se) begin
            r = -q - s;
        end else begin
            s = -q - r;
        end
        qc = saturate(q);
        rc = saturate(r);
        sc = saturate(s);
        pred.cell_q   = qc[COORD_W-1:0];
        pred.cell_r   = rc[COORD_W-1:0];
        pred.cell_s   = sc[COORD_W-1:0];
        pred.overflow = (qc != q) || (rc != r) || (sc != s);
        return pred;
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord(logic signed [COORD_W-1:0] centre);
        int pick;
        pick = $urandom_range(9);
        if (pick < 4) return COORD_W'($urandom);
        if (pick < 8) return COORD_W'(int'(centre) + int'($urandom_range(128)) - 64);
        if (pick == 8) return $urandom_range(1) ? COORD_W'(COORD_MAX) : COORD_W'(COORD_MIN);
        return COORD_W'(int'($urandom_range(4)) - 2);
    endfunction

    function automatic logic [COEF_W-1:0] modest_coef();
        return COEF_W'(int'($urandom_range(2097152)) - 1048576);
    endfunction

    // Input driver: a new beat is offered only when the previous one was taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                cell_expect.push_back(predict_cell(i_in_data));
            end
            if (!i_in_valid || o_in_ready) begin
                if (pix_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pix_queue.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : cell_monitor
        t_cell_out want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (cell_expect.size() == 0) begin
                    $error("result beat with no pixel waiting for it");
                    fail_count++;
                end else begin
                    want = cell_expect.pop_front();
                    if (o_out_data.cell_q !== want.cell_q) begin
                        $error("cell_q: expected %0d, actual %0d", want.cell_q,
                               o_out_data.cell_q);
                        fail_count++;
                    end
                    if (o_out_data.cell_r !== want.cell_r) begin
                        $error("cell_r: expected %0d, actual %0d", want.cell_r,
                               o_out_data.cell_r);
                        fail_count++;
                    end
                    if (o_out_data.cell_s !== want.cell_s) begin
                        $error("cell_s: expected %0d, actual %0d", want.cell_s,
                               o_out_data.cell_s);
                        fail_count++;
                    end
                    if (o_out_data.overflow !== want.overflow) begin
                        $error("overflow: expected %0b, actual %0b", want.overflow,
                               o_out_data.overflow);
                        fail_count++;
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_COEF_Q_X: cfg_qx = val;
            CFG_COEF_Q_Y: cfg_qy = val;
            CFG_COEF_R_X: cfg_rx = val;
            CFG_COEF_R_Y: cfg_ry = val;
            CFG_ORIGIN_X: cfg_ox = val[COORD_W-1:0];
            CFG_ORIGIN_Y: cfg_oy = val[COORD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [COEF_W-1:0] qx, logic [COEF_W-1:0] qy,
                              logic [COEF_W-1:0] rx, logic [COEF_W-1:0] ry,
                              logic [COEF_W-1:0] ox, logic [COEF_W-1:0] oy);
        write_reg(CFG_COEF_Q_X, qx);
        write_reg(CFG_COEF_Q_Y, qy);
        write_reg(CFG_COEF_R_X, rx);
        write_reg(CFG_COEF_R_Y, ry);
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
    endtask

    task automatic push_pix(int x, int y);
        t_pix_in p;
        p.pixel_x = x[COORD_W-1:0];
        p.pixel_y = y[COORD_W-1:0];
        pix_queue.push_back(p);
    endtask

    task automatic wait_drained();
        while (pix_queue.size() != 0 || i_in_valid || cell_expect.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(int count, int send_pct, int recv_pct);
        t_pix_in p;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count) begin
            p.pixel_x = rand_coord(cfg_ox);
            p.pixel_y = rand_coord(cfg_oy);
            pix_queue.push_back(p);
        end
        wait_drained();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset coefficients, with directed pixels including the corners of the pixel range first.
        push_pix(0, 0);
        push_pix(32767, 32767);
        push_pix(-32768, -32768);
        push_pix(32767, -32768);
        push_pix(-32768, 32767);
        push_pix(1, 1);
        push_pix(-1, -1);
        push_pix(0, 32767);
        push_pix(-32768, 0);
        push_pix(17, -9);
        push_pix(100, 50);
        run_phase(240, 0, 0);

        set_config(COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom),
                   COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom));
        run_phase(240, 78, 0);

        // Largest weights against the lowest origin saturate the coordinates of pixels far from it.
        set_config(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, ORG_MIN, ORG_MIN);
        write_reg(CFG_SPARE_A, COEF_W'($urandom));
        write_reg(CFG_SPARE_B, COEF_W'($urandom));
        push_pix(32767, 32767);
        push_pix(-32768, -32768);
        push_pix(32767, -32768);
        run_phase(240, 0, 78);

        set_config(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, ORG_MAX, ORG_MAX);
        push_pix(-32768, -32768);
        push_pix(32767, 32767);
        push_pix(-32768, 32767);
        run_phase(240, 17, 17);

        set_config(modest_coef(), modest_coef(), modest_coef(), modest_coef(),
                   COEF_W'($urandom), COEF_W'($urandom));
        run_phase(240, 0, 0);

        // All weights zero leaves every error equal, so s is always rebuilt.
        set_config('0, '0, '0, '0, COEF_W'($urandom), COEF_W'($urandom));
        run_phase(240, 78, 0);

        // Half-cell weights make odd offsets land exactly on a half.
        set_config(COEF_HALF, '0, '0, COEF_HALF, '0, '0);
        push_pix(1, 1);
        push_pix(1, 0);
        push_pix(0, 1);
        push_pix(-1, 0);
        push_pix(-1, -1);
        push_pix(3, -2);
        push_pix(-5, 4);
        run_phase(240, 0, 78);

        set_config(modest_coef(), modest_coef(), modest_coef(), modest_coef(),
                   COEF_W'($urandom), COEF_W'($urandom));
        run_phase(240, 17, 17);

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/p2h_pkg.sv
rtl/p2h_round.sv
rtl/pixel_to_hex_cell_round.sv
rtl/p2h_chk.sv
dv/pixel_to_hex_cell_round_test.sv
